// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ccg_pkg.sv
`default_nettype none

package ccg_pkg;

    localparam int MAX_LEN   = 4096;
    localparam int FRAC_BITS = 28;

    localparam int DATA_W    = 32;
    localparam int CFG_LEN_W = 13;
    localparam int CFG_IDX_W = 3;
    localparam int POS_W     = $clog2(MAX_LEN);
    localparam int LEN_W     = POS_W + 1;

    localparam logic signed [DATA_W-1:0] FIX_ONE = DATA_W'(1) << FRAC_BITS;
    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INIT_STEP_REAL = 3'd0,
        CFG_INIT_STEP_IMAG = 3'd1,
        CFG_RATIO_REAL     = 3'd2,
        CFG_RATIO_IMAG     = 3'd3,
        CFG_SEQ_LENGTH     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] init_step_real;
        logic signed [DATA_W-1:0] init_step_imag;
        logic signed [DATA_W-1:0] ratio_real;
        logic signed [DATA_W-1:0] ratio_imag;
        logic [LEN_W-1:0]         seq_len;
    } t_cfg;

    typedef struct packed {
        logic signed [DATA_W-1:0] coef_real;
        logic signed [DATA_W-1:0] coef_imag;
        logic [POS_W-1:0]         coef_index;
        logic                     last;
        logic                     saturated;
    } t_result;

endpackage

`default_nettype wire

// File: src/ccg_cfg.sv
`default_nettype none

module ccg_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [ccg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ccg_pkg::DATA_W-1:0]      i_cfg_data,
    output ccg_pkg::t_cfg                   o_cfg
);
    import ccg_pkg::*;

    t_cfg                 r_cfg;
    t_cfg                 n_cfg;
    logic [CFG_LEN_W-1:0] len_raw;
    logic [LEN_W-1:0]     len_clamped;

    assign len_raw = i_cfg_data[CFG_LEN_W-1:0];

    // A length of zero acts as one, and anything above the maximum acts as the maximum.
    always_comb begin
        if (len_raw == '0) begin
            len_clamped = LEN_W'(1);
        end else if (32'(len_raw) > 32'(MAX_LEN)) begin
            len_clamped = LEN_W'(MAX_LEN);
        end else begin
            len_clamped = LEN_W'(len_raw);
        end
    end

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_INIT_STEP_REAL: n_cfg.init_step_real = i_cfg_data;
                CFG_INIT_STEP_IMAG: n_cfg.init_step_imag = i_cfg_data;
                CFG_RATIO_REAL:     n_cfg.ratio_real     = i_cfg_data;
                CFG_RATIO_IMAG:     n_cfg.ratio_imag     = i_cfg_data;
                CFG_SEQ_LENGTH:     n_cfg.seq_len        = len_clamped;
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.init_step_real <= FIX_ONE;
            r_cfg.init_step_imag <= '0;
            r_cfg.ratio_real     <= FIX_ONE;
            r_cfg.ratio_imag     <= '0;
            r_cfg.seq_len        <= LEN_W'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: src/ccg_cmul.sv
`default_nettype none

module ccg_cmul (
    input  logic signed [ccg_pkg::DATA_W-1:0] i_a_real,
    input  logic signed [ccg_pkg::DATA_W-1:0] i_a_imag,
    input  logic signed [ccg_pkg::DATA_W-1:0] i_b_real,
    input  logic signed [ccg_pkg::DATA_W-1:0] i_b_imag,
    output logic signed [ccg_pkg::DATA_W-1:0] o_p_real,
    output logic signed [ccg_pkg::DATA_W-1:0] o_p_imag,
    output logic                              o_sat
);
    import ccg_pkg::*;

    localparam int PROD_W = 2 * DATA_W;
    localparam int SUM_W  = PROD_W + 1;

    logic signed [PROD_W-1:0] prod_rr;
    logic signed [PROD_W-1:0] prod_ii;
    logic signed [PROD_W-1:0] prod_ri;
    logic signed [PROD_W-1:0] prod_ir;
    logic signed [SUM_W-1:0]  sum_real;
    logic signed [SUM_W-1:0]  sum_imag;
    logic signed [SUM_W-1:0]  shr_real;
    logic signed [SUM_W-1:0]  shr_imag;
    logic                     ovf_real;
    logic                     ovf_imag;

    assign prod_rr = i_a_real * i_b_real;
    assign prod_ii = i_a_imag * i_b_imag;
    assign prod_ri = i_a_real * i_b_imag;
    assign prod_ir = i_a_imag * i_b_real;

    // The exact sum shifted arithmetically is the floor of the scaled product.
    assign sum_real = SUM_W'(prod_rr) - SUM_W'(prod_ii);
    assign sum_imag = SUM_W'(prod_ri) + SUM_W'(prod_ir);
    assign shr_real = sum_real >>> FRAC_BITS;
    assign shr_imag = sum_imag >>> FRAC_BITS;

    assign ovf_real = !((&shr_real[SUM_W-1:DATA_W-1]) || !(|shr_real[SUM_W-1:DATA_W-1]));
    assign ovf_imag = !((&shr_imag[SUM_W-1:DATA_W-1]) || !(|shr_imag[SUM_W-1:DATA_W-1]));

    always_comb begin
        if (ovf_real) begin
            o_p_real = shr_real[SUM_W-1] ? SAT_MIN : SAT_MAX;
        end else begin
            o_p_real = shr_real[DATA_W-1:0];
        end
        if (ovf_imag) begin
            o_p_imag = shr_imag[SUM_W-1] ? SAT_MIN : SAT_MAX;
        end else begin
            o_p_imag = shr_imag[DATA_W-1:0];
        end
    end

    assign o_sat = ovf_real || ovf_imag;

endmodule

`default_nettype wire

// File: src/ccg_seq.sv
`default_nettype none

module ccg_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_restart,
    input  ccg_pkg::t_cfg     i_cfg,
    output ccg_pkg::t_result  o_result
);
    import ccg_pkg::*;

    logic signed [DATA_W-1:0] r_chirp_real;
    logic signed [DATA_W-1:0] r_chirp_imag;
    logic signed [DATA_W-1:0] r_step_real;
    logic signed [DATA_W-1:0] r_step_imag;
    logic [POS_W-1:0]         r_pos;
    logic signed [DATA_W-1:0] n_chirp_real;
    logic signed [DATA_W-1:0] n_chirp_imag;
    logic signed [DATA_W-1:0] n_step_real;
    logic signed [DATA_W-1:0] n_step_imag;
    logic [POS_W-1:0]         n_pos;
    logic signed [DATA_W-1:0] chirp_mul_real;
    logic signed [DATA_W-1:0] chirp_mul_imag;
    logic signed [DATA_W-1:0] step_mul_real;
    logic signed [DATA_W-1:0] step_mul_imag;
    logic                     chirp_sat;
    logic                     step_sat;
    logic                     start;
    logic [POS_W-1:0]         idx;
    logic [LEN_W-1:0]         idx_next;
    logic                     is_last;

    ccg_cmul u_chirp_mul (
        .i_a_real (r_chirp_real),
        .i_a_imag (r_chirp_imag),
        .i_b_real (r_step_real),
        .i_b_imag (r_step_imag),
        .o_p_real (chirp_mul_real),
        .o_p_imag (chirp_mul_imag),
        .o_sat    (chirp_sat)
    );

    ccg_cmul u_step_mul (
        .i_a_real (r_step_real),
        .i_a_imag (r_step_imag),
        .i_b_real (i_cfg.ratio_real),
        .i_b_imag (i_cfg.ratio_imag),
        .o_p_real (step_mul_real),
        .o_p_imag (step_mul_imag),
        .o_sat    (step_sat)
    );

    // A new sequence begins on request, at position zero, or when the length no longer exceeds it.
    assign start    = i_restart || (r_pos == '0) || ({1'b0, r_pos} >= i_cfg.seq_len);
    assign idx      = start ? '0 : r_pos;
    assign idx_next = {1'b0, idx} + LEN_W'(1);
    assign is_last  = idx_next >= i_cfg.seq_len;

    always_comb begin
        if (start) begin
            n_chirp_real = FIX_ONE;
            n_chirp_imag = '0;
            n_step_real  = i_cfg.init_step_real;
            n_step_imag  = i_cfg.init_step_imag;
        end else begin
            n_chirp_real = chirp_mul_real;
            n_chirp_imag = chirp_mul_imag;
            n_step_real  = step_mul_real;
            n_step_imag  = step_mul_imag;
        end
        n_pos = is_last ? '0 : idx_next[POS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chirp_real <= FIX_ONE;
            r_chirp_imag <= '0;
            r_step_real  <= '0;
            r_step_imag  <= '0;
            r_pos        <= '0;
        end else if (i_accept) begin
            r_chirp_real <= n_chirp_real;
            r_chirp_imag <= n_chirp_imag;
            r_step_real  <= n_step_real;
            r_step_imag  <= n_step_imag;
            r_pos        <= n_pos;
        end
    end

    assign o_result.coef_real  = n_chirp_real;
    assign o_result.coef_imag  = n_chirp_imag;
    assign o_result.coef_index = idx;
    assign o_result.last       = is_last;
    assign o_result.saturated  = !start && (chirp_sat || step_sat);

endmodule

`default_nettype wire

// File: src/complex_chirp_generator.sv
`default_nettype none

// Chirp coefficient generator for a chirp z-transform. Each input transfer yields one
// complex coefficient in Q3.28: the first of a sequence is 1+0j and loads the step from
// the initial-step registers; each later one is chirp*step, after which the step is
// multiplied by the ratio. The sequence wraps after seq_length coefficients, and a
// restart transfer begins a new one at any time. One transfer is taken every clock cycle
// while the output register is empty or being read, and its result is captured there
// as the transfer is accepted. This rate rests on the recurrence on the chirp and step
// state: both complex products (eight parallel 32x32 multipliers, floored and saturated)
// are combinational. Configuration writes take effect on the cycle after the write enable.
module complex_chirp_generator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_restart,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [ccg_pkg::DATA_W-1:0]  o_coef_real,
    output logic signed [ccg_pkg::DATA_W-1:0]  o_coef_imag,
    output logic [ccg_pkg::POS_W-1:0]          o_coef_index,
    output logic                               o_last,
    output logic                               o_saturated,
    input  logic                               i_cfg_wr_en,
    input  logic [ccg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ccg_pkg::DATA_W-1:0]         i_cfg_data
);
    import ccg_pkg::*;

    t_cfg    cfg;
    t_result result;
    t_result r_result;
    logic    r_out_valid;
    logic    in_accept;

    ccg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ccg_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_restart (i_restart),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_coef_real  = r_result.coef_real;
    assign o_coef_imag  = r_result.coef_imag;
    assign o_coef_index = r_result.coef_index;
    assign o_last       = r_result.last;
    assign o_saturated  = r_result.saturated;

`include "assert_macros.svh"

    `ASSERT_SAME(a_first_is_one, i_clk, i_rst_n,
        o_out_valid && (o_coef_index == '0),
        (o_coef_real == FIX_ONE) && (o_coef_imag == '0) && !o_saturated,
        "first coefficient of a sequence is not 1+0j")

    `ASSERT_SAME(a_index_in_range, i_clk, i_rst_n,
        o_out_valid, {1'b0, o_coef_index} < cfg.seq_len,
        "coefficient index not below the sequence length")

    `ASSERT_NEXT(a_restart_index, i_clk, i_rst_n,
        in_accept && i_restart, o_out_valid && (o_coef_index == '0),
        "restart transfer did not produce index zero")

endmodule

`default_nettype wire
